/* rtl/core/binary_heap_priority_queue_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the binary heap priority queue
// Shared forms for concurrent checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bhpq_pkg.sv */
// ----------------------------------------------------------------------------
// Binary heap priority queue package
// Sizes, codes, interface structures and the ordering function.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int DEPTH       = 1024;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = ADDR_W + 2;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 11;
  localparam int OUT_CNT_W   = 11;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = ((DATA_W + OUT_CNT_W + 7) / 8) * 8;

  localparam logic [CAP_W-1:0]         CAP_RESET  = CAP_W'(1024);
  localparam logic signed [DATA_W-1:0] EMPTY_ROOT = -DATA_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  typedef enum logic {
    CFG_ORDER    = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_POP_LOAD,
    S_DOWN,
    S_DOWN_CMP,
    S_PEEK_LOAD
  } eng_state_t;

  typedef struct packed {
    logic             order_is_max;
    logic [CNT_W-1:0] limit;
  } bhpq_cfg_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [DATA_W-1:0]  value;
  } bhpq_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] root_value;
    status_t                  status;
    logic [OUT_CNT_W-1:0]     count;
  } bhpq_rsp_t;

  function automatic logic nearer_root(input logic order_is_max,
                                       input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b);
    nearer_root = order_is_max ? (a > b) : (a < b);
  endfunction

endpackage

/* rtl/core/binary_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Overflow, underflow and the unused command are answered from idle; peek
// reads the root; push and pop move L levels, at most 9 at 1024 entries,
// and a sift ends on a compare, at the root or at a leaf. One command is in
// flight; the next is taken once the engine is idle and the result is free.
// Synchronous active-low reset empties the heap, selects min ordering and
// sets the capacity to 1024; the heap memory itself is not cleared.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [bhpq_pkg::DATA_W-1:0]           in_tdata,   // value
  input  logic [bhpq_pkg::CMD_W-1:0]            in_tuser,   // cmd
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [bhpq_pkg::OUT_TDATA_W-1:0]      out_tdata,  // root_value, count
  output logic [bhpq_pkg::STATUS_W-1:0]         out_tuser,  // status
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [bhpq_pkg::CAP_W-1:0]            cfg_wdata
);
  import bhpq_pkg::*;

  logic                   order_r, order_nxt;
  logic [CAP_W-1:0]       cap_r, cap_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [STATUS_W-1:0]    out_user_r, out_user_nxt;

  bhpq_cfg_t cfg;
  bhpq_req_t req;
  bhpq_rsp_t rsp;
  logic      eng_idle, eng_done, start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= 1'b0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      order_r     <= order_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_comb begin
    order_nxt = order_r;
    cap_nxt   = cap_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORDER:    order_nxt = cfg_wdata[0];
        CFG_CAPACITY: cap_nxt   = cfg_wdata;
        default:      cap_nxt   = cap_r;
      endcase
    end
  end

  assign cfg.order_is_max = order_r;
  assign cfg.limit        = (CMP_W'(cap_r) > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_r);

  assign req.cmd   = cmd_t'(in_tuser);
  assign req.value = in_tdata;

  assign in_tready = eng_idle && (!out_valid_r || out_tready);
  assign start     = in_tvalid && in_tready;

  bhpq_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (req),
    .cfg   (cfg),
    .idle  (eng_idle),
    .done  (eng_done),
    .rsp   (rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (eng_done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_TDATA_W'({rsp.count, rsp.root_value});
      out_user_nxt  = rsp.status;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* rtl/core/bhpq_engine.sv */
// ----------------------------------------------------------------------------
// Heap engine
// Holds the heap in a two-read, one-write memory and sifts entries up or down
// one level at a time, carrying the moving value in a register.
// ----------------------------------------------------------------------------
module bhpq_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bhpq_pkg::bhpq_req_t req,
  input  bhpq_pkg::bhpq_cfg_t cfg,
  output logic                idle,
  output logic                done,
  output bhpq_pkg::bhpq_rsp_t rsp
);
  import bhpq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  eng_state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]        pos_r, pos_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] top_r, top_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;

  logic                     we;
  logic [ADDR_W-1:0]        wa, ra_a, ra_b;
  logic signed [DATA_W-1:0] wd;
  logic signed [DATA_W-1:0] rd_a_r, rd_b_r;

  logic [ADDR_W-1:0]        parent;
  logic [IDX_W-1:0]         left, right, cnt_ext;
  logic                     has_left, has_right, pick_right;
  logic signed [DATA_W-1:0] pick_val;
  logic [ADDR_W-1:0]        pick_idx;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[ra_a];
    rd_b_r <= mem[ra_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    top_r <= top_nxt;
  end

  assign parent     = ADDR_W'((pos_r - ADDR_W'(1)) >> 1);
  assign left       = IDX_W'({pos_r, 1'b1});
  assign right      = left + IDX_W'(1);
  assign cnt_ext    = IDX_W'(count_r);
  assign has_left   = left < cnt_ext;
  assign has_right  = right < cnt_ext;
  assign pick_right = has_right && !nearer_root(cfg.order_is_max, rd_a_r, rd_b_r);
  assign pick_val   = pick_right ? rd_b_r : rd_a_r;
  assign pick_idx   = pick_right ? right[ADDR_W-1:0] : left[ADDR_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    top_nxt        = top_r;
    count_nxt      = count_r;
    we             = 1'b0;
    wa             = pos_r;
    wd             = val_r;
    ra_a           = parent;
    ra_b           = '0;
    done           = 1'b0;
    rsp.root_value = '0;
    rsp.status     = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (req.cmd)
            CMD_PUSH: begin
              if (CMP_W'(count_r) >= CMP_W'(cfg.limit)) begin
                done       = 1'b1;
                rsp.status = ST_OVER;
              end else begin
                pos_nxt   = ADDR_W'(count_r);
                val_nxt   = req.value;
                count_nxt = count_r + CNT_W'(1);
                state_nxt = S_UP;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (count_r == '0) begin
                done           = 1'b1;
                rsp.root_value = EMPTY_ROOT;
                rsp.status     = ST_UNDER;
              end else begin
                ra_a      = '0;
                ra_b      = ADDR_W'(count_r - CNT_W'(1));
                state_nxt = (req.cmd == CMD_POP) ? S_POP_LOAD : S_PEEK_LOAD;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (nearer_root(cfg.order_is_max, val_r, rd_a_r)) begin
          wd        = rd_a_r;
          pos_nxt   = parent;
          state_nxt = S_UP;
        end else begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_POP_LOAD: begin
        top_nxt   = rd_a_r;
        val_nxt   = rd_b_r;
        count_nxt = count_r - CNT_W'(1);
        pos_nxt   = '0;
        state_nxt = S_DOWN;
      end
      S_DOWN: begin
        if (has_left) begin
          ra_a      = left[ADDR_W-1:0];
          ra_b      = right[ADDR_W-1:0];
          state_nxt = S_DOWN_CMP;
        end else begin
          we             = 1'b1;
          done           = 1'b1;
          rsp.root_value = top_r;
          state_nxt      = S_IDLE;
        end
      end
      S_DOWN_CMP: begin
        we = 1'b1;
        if (nearer_root(cfg.order_is_max, pick_val, val_r)) begin
          wd        = pick_val;
          pos_nxt   = pick_idx;
          state_nxt = S_DOWN;
        end else begin
          done           = 1'b1;
          rsp.root_value = top_r;
          state_nxt      = S_IDLE;
        end
      end
      S_PEEK_LOAD: begin
        done           = 1'b1;
        rsp.root_value = rd_a_r;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rsp.count = OUT_CNT_W'(count_nxt);
  end

  assign idle = (state_r == S_IDLE);

endmodule

/* rtl/core/bhpq_checker.sv */
// ----------------------------------------------------------------------------
// Binary heap priority queue port checker
// Watches the result channel of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`include "binary_heap_priority_queue_assert.svh"

module bhpq_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [bhpq_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input logic [bhpq_pkg::STATUS_W-1:0]         out_tuser
);
  import bhpq_pkg::*;

  logic [OUT_CNT_W-1:0] out_count;
  logic [DATA_W-1:0]    out_root;

  assign out_count = out_tdata[DATA_W +: OUT_CNT_W];
  assign out_root  = out_tdata[DATA_W-1:0];

  `BHPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")

  `BHPQ_ASSERT_SAME(a_under_empty, clk, rst_n, out_tvalid && out_tuser == ST_UNDER,
    out_root == EMPTY_ROOT && out_count == '0, "underflow beat must be minus one on an empty heap")

  `BHPQ_ASSERT_SAME(a_over_zero, clk, rst_n, out_tvalid && out_tuser == ST_OVER,
    out_root == '0, "overflow beat must carry a zero root value")

  `BHPQ_ASSERT_SAME(a_count_bound, clk, rst_n, out_tvalid,
    out_count <= OUT_CNT_W'(DEPTH), "entry count beyond the heap depth")

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the binary heap priority queue
// Drives push, pop, peek and unused commands through the input stream. The
// register settings cover both orderings and capacities of zero, one, a few,
// a lowered limit, full depth and beyond. A shadow heap predicts every
// result, and the scoreboard compares each result beat, field by field, with
// the oldest outstanding prediction. The sender works in random bursts and
// the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module tb_top;
  import bhpq_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 40;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_CHOKE
  } rx_mode_t;

  class heap_tracker;
    logic signed [DATA_W-1:0] slots [DEPTH];
    int unsigned              held;
    bit                       max_first;
    int unsigned              cap_reg;
    bhpq_rsp_t                awaited_rsp [$];
    int unsigned              mismatches;
    int unsigned              results_seen;
    int unsigned              pushes;
    int unsigned              overflows;
    int unsigned              underflows;
    int unsigned              peak_held;

    function new();
      held = 0;
      max_first = 1'b0;
      cap_reg = 1024;
      mismatches = 0;
      results_seen = 0;
      pushes = 0;
      overflows = 0;
      underflows = 0;
      peak_held = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CAP_W-1:0] val);
      if (idx == CFG_ORDER) begin
        max_first = val[0];
      end else begin
        cap_reg = val;
      end
    endfunction

    function bit outranks(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
      return max_first ? (a > b) : (a < b);
    endfunction

    function void swap_slots(int unsigned i, int unsigned j);
      logic signed [DATA_W-1:0] t;
      t = slots[i];
      slots[i] = slots[j];
      slots[j] = t;
    endfunction

    function void note_command(cmd_t c, logic [DATA_W-1:0] v);
      bhpq_rsp_t   r;
      int unsigned pos;
      int unsigned up;
      int unsigned kid;
      int unsigned lim;
      bit          done;
      r.root_value = '0;
      r.status = ST_OK;
      lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
      case (c)
        CMD_PUSH: begin
          if (held >= lim) begin
            r.status = ST_OVER;
            overflows++;
          end else begin
            pos = held;
            slots[pos] = v;
            done = 1'b0;
            while (pos > 0 && !done) begin
              up = (pos - 1) / 2;
              if (outranks(slots[pos], slots[up])) begin
                swap_slots(pos, up);
                pos = up;
              end else begin
                done = 1'b1;
              end
            end
            held++;
            pushes++;
            if (held > peak_held) peak_held = held;
          end
        end
        CMD_POP, CMD_PEEK: begin
          if (held == 0) begin
            r.root_value = EMPTY_ROOT;
            r.status = ST_UNDER;
            underflows++;
          end else begin
            r.root_value = slots[0];
            if (c == CMD_POP) begin
              held--;
              slots[0] = slots[held];
              pos = 0;
              done = 1'b0;
              while (2 * pos + 1 < held && !done) begin
                kid = 2 * pos + 1;
                if (kid + 1 < held && !outranks(slots[kid], slots[kid + 1])) kid++;
                if (outranks(slots[kid], slots[pos])) begin
                  swap_slots(pos, kid);
                  pos = kid;
                end else begin
                  done = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
      r.count = OUT_CNT_W'(held);
      awaited_rsp.push_back(r);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("Mismatch at %0t: %s", $realtime, what);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser);
      bhpq_rsp_t got;
      bhpq_rsp_t want;
      got.root_value = tdata[DATA_W-1:0];
      got.count = tdata[DATA_W +: OUT_CNT_W];
      got.status = status_t'(tuser);
      results_seen++;
      if (awaited_rsp.size() == 0) begin
        report($sformatf("result beat with nothing outstanding (root %0d, status %0d, count %0d)",
                         got.root_value, got.status, got.count));
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.root_value !== want.root_value)
        report($sformatf("root_value expected %0d, got %0d", want.root_value, got.root_value));
      if (got.status !== want.status)
        report($sformatf("status expected %0d, got %0d", want.status, got.status));
      if (got.count !== want.count)
        report($sformatf("count expected %0d, got %0d", want.count, got.count));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = 1'b0;
  logic [CAP_W-1:0]       cfg_wdata = '0;

  heap_tracker tracker = new();
  int unsigned cycle_count = 0;
  int unsigned rx_tick = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned burst_left = 0;
  int unsigned settings_used = 1;

  binary_heap_priority_queue i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               tracker.awaited_rsp.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver back-pressure: each stretch draws one of four random ready patterns.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 97 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_tready <= (rx_tick % 3) != 2;
      default:     out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Outputs are stable between edges, so a beat seen here is taken at the next edge.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata, out_tuser);
  end

  task automatic send_item(cmd_t c, logic [DATA_W-1:0] v);
    bit taken;
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= v;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    tracker.note_command(c, v);
  endtask

  task automatic idle(int unsigned n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.awaited_rsp.size() != 0);
  endtask

  task automatic configure(logic order, logic [CAP_W-1:0] cap);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ORDER;
    cfg_wdata <= CAP_W'(order);
    @(posedge clk);
    tracker.set_reg(CFG_ORDER, CAP_W'(order));
    cfg_index <= CFG_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    tracker.set_reg(CFG_CAPACITY, cap);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       pick_value = DATA_W'($urandom_range(0, 9)) - DATA_W'(5);
      1:       pick_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: pick_value = $urandom();
    endcase
  endfunction

  function automatic cmd_t pick_cmd(int unsigned push_pct, int unsigned pop_pct,
                                    int unsigned peek_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return CMD_PUSH;
    if (r < push_pct + pop_pct) return CMD_POP;
    if (r < push_pct + pop_pct + peek_pct) return CMD_PEEK;
    return CMD_NOP;
  endfunction

  task automatic run_mix(int unsigned n, int unsigned push_pct, int unsigned pop_pct,
                         int unsigned peek_pct);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 4) == 0) begin
          burst_left = 40;
        end else begin
          idle($urandom_range(1, 6));
          burst_left = $urandom_range(1, 12);
        end
      end
      burst_left--;
      send_item(pick_cmd(push_pct, pop_pct, peek_pct), pick_value());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: min ordering, full capacity.
    send_item(CMD_PEEK, 32'h0000_0000);
    send_item(CMD_POP, 32'hFFFF_FFFF);
    send_item(CMD_NOP, 32'h1234_5678);
    send_item(CMD_PUSH, 32'h7FFF_FFFF);
    send_item(CMD_PUSH, 32'h8000_0000);
    send_item(CMD_PUSH, 32'h0000_0000);
    send_item(CMD_PUSH, 32'hFFFF_FFFF);
    send_item(CMD_PEEK, 32'h0000_0000);
    send_item(CMD_PUSH, 32'd5);
    send_item(CMD_PUSH, 32'd5);
    send_item(CMD_PUSH, 32'd5);
    send_item(CMD_PUSH, 32'd1);
    send_item(CMD_NOP, 32'hFFFF_FFFF);
    send_item(CMD_POP, 32'h0000_0000);
    send_item(CMD_POP, 32'h0000_0000);
    send_item(CMD_POP, 32'h0000_0000);
    send_item(CMD_POP, 32'h0000_0000);
    send_item(CMD_PEEK, 32'h0000_0000);
    send_item(CMD_POP, 32'h0000_0000);
    send_item(CMD_POP, 32'h0000_0000);
    send_item(CMD_POP, 32'h0000_0000);
    send_item(CMD_POP, 32'h0000_0000);
    send_item(CMD_POP, 32'h0000_0000);
    settle();

    configure(1'b1, CAP_W'(5));
    run_mix(100, 45, 30, 15);
    settle();

    // Zero capacity: pushes overflow while pops drain what is left.
    configure(1'b1, CAP_W'(0));
    run_mix(30, 50, 35, 10);
    settle();

    configure(1'b0, CAP_W'(1));
    run_mix(40, 45, 30, 15);
    settle();

    // Capacity beyond the depth: a deep heap is built without any push refused.
    configure(1'b1, CAP_W'(1025));
    run_mix(600, 100, 0, 0);
    settle();

    // Ordering flipped on a deep heap, limit lowered below the count.
    configure(1'b0, CAP_W'(500));
    run_mix(100, 20, 70, 8);
    settle();

    configure(1'b0, CAP_W'(1024));
    run_mix(60, 40, 40, 15);
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results over %0d register settings: %0d pushes kept, %0d overflows,",
             tracker.results_seen, settings_used, tracker.pushes, tracker.overflows);
    $display("%0d underflows, peak occupancy %0d entries.", tracker.underflows,
             tracker.peak_held);
    if (tracker.mismatches == 0 && tracker.awaited_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never arrived", tracker.mismatches,
               tracker.awaited_rsp.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bhpq_pkg.sv
rtl/core/bhpq_engine.sv
rtl/core/binary_heap_priority_queue.sv
rtl/core/bhpq_checker.sv
bench/tb_top.sv
